[rtl/bsc_pkg.sv]
// Shared types and constants for the binary subsequence counter.
// Used by bsc_cell and binary_subsequence_count; no dependencies.
package bsc_pkg;

    localparam int DATA_W  = 64;  // letter vectors and counts
    localparam int LEN_W   = 7;   // length fields
    localparam int S_TDATA_W = 144; // 142 field bits padded to whole bytes

    // broadcast controls for the cell row
    typedef struct packed {
        logic start;   // clear counts, latch subword letters
        logic step;    // consume one word letter
        logic letter;  // current word letter
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

endpackage

[rtl/bsc_cell.sv]
// One counter cell of the subsequence count row.
// Depends on bsc_pkg for the control struct and widths.
module bsc_cell (
    input  logic                         i_clk,
    input  bsc_pkg::t_cell_ctrl          i_ctrl,
    input  logic                         i_sub_letter,
    input  logic [bsc_pkg::DATA_W-1:0]   i_prev_count,
    output logic [bsc_pkg::DATA_W-1:0]   o_count
);
    import bsc_pkg::*;

    logic              r_sub_letter;
    logic [DATA_W-1:0] r_count;
    logic [DATA_W-1:0] n_count;

    // neighbor's count is the value before this letter, as in a top-down update
    always_comb begin
        n_count = r_count;
        if (i_ctrl.start) begin
            n_count = '0;
        end else if (i_ctrl.step && (r_sub_letter == i_ctrl.letter)) begin
            n_count = r_count + i_prev_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
        if (i_ctrl.start) begin
            r_sub_letter <= i_sub_letter;
        end
    end

    assign o_count = r_count;

endmodule

[rtl/binary_subsequence_count.sv]
// Binary subsequence counter: top level with control, cell row and output register.
// Depends on bsc_pkg and bsc_cell.
//
// Counts the ways a subword occurs as a scattered subsequence of a word. An item is
// accepted, then its word letters are consumed, then the result is posted once the
// output register is free or being read; an item whose subword is empty or longer
// than the word skips the letters. The cell row consumes one word letter per cycle,
// broadcast to all cells; each matching cell adds its lower neighbor's count.
// One item is in work at a time; the result waits in an output register, so the
// next item is accepted while it is still pending. No clearing pass is needed.
module binary_subsequence_count #(
    parameter int MAX_LETTERS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // word_bits[63:0], word_length[70:64], sub_bits[134:71], sub_length[141:135]
    input  logic [bsc_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // occurrence_count[63:0]
    output logic [bsc_pkg::DATA_W-1:0]      o_m_tdata
);
    import bsc_pkg::*;

    localparam int CW = $clog2(MAX_LETTERS + 1);

    t_state            r_state, n_state;
    logic [DATA_W-1:0] r_word, n_word;
    logic [LEN_W-1:0]  r_left, n_left;
    logic [CW-1:0]     r_slen, n_slen;
    logic              r_zero, n_zero;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out, n_out;

    logic [DATA_W-1:0] w_word_in, w_sub_in, w_sub_al;
    logic [LEN_W-1:0]  w_wlen_raw, w_slen_raw, w_wlen, w_slen;
    logic              w_accept, w_finish, w_degen;
    t_cell_ctrl        w_ctrl;
    logic [DATA_W-1:0] w_count [0:MAX_LETTERS];

    assign w_word_in  = i_s_tdata[63:0];
    assign w_wlen_raw = i_s_tdata[70:64];
    assign w_sub_in   = i_s_tdata[134:71];
    assign w_slen_raw = i_s_tdata[141:135];

    assign w_wlen = (w_wlen_raw > LEN_W'(MAX_LETTERS)) ? LEN_W'(MAX_LETTERS) : w_wlen_raw;
    assign w_slen = (w_slen_raw > LEN_W'(MAX_LETTERS)) ? LEN_W'(MAX_LETTERS) : w_slen_raw;

    // first letter lands in bit 63 for both vectors
    assign w_sub_al = w_sub_in << (LEN_W'(DATA_W) - w_slen);

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_degen    = (w_slen == '0) || (w_slen > w_wlen);
    assign w_finish   = (r_state == S_RUN) && (r_left == '0) && (!r_out_valid || i_m_tready);

    assign w_ctrl.start  = w_accept;
    assign w_ctrl.step   = (r_state == S_RUN) && (r_left != '0);
    assign w_ctrl.letter = r_word[DATA_W-1];

    assign w_count[0] = DATA_W'(1);

    for (genvar j = 1; j <= MAX_LETTERS; j++) begin : g_cell
        bsc_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_sub_letter (w_sub_al[DATA_W-j]),
            .i_prev_count (w_count[j-1]),
            .o_count      (w_count[j])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_left      = r_left;
        n_slen      = r_slen;
        n_zero      = r_zero;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_word  = w_word_in << (LEN_W'(DATA_W) - w_wlen);
                    n_left  = w_degen ? '0 : w_wlen;
                    n_slen  = CW'(w_slen);
                    n_zero  = (w_slen > w_wlen);
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_left != '0) begin
                    n_word = r_word << 1;
                    n_left = r_left - LEN_W'(1);
                end else if (w_finish) begin
                    n_out_valid = 1'b1;
                    n_out       = r_zero ? '0 : w_count[r_slen];
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
        r_word <= n_word;
        r_slen <= n_slen;
        r_zero <= n_zero;
        r_out  <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while an item was in work");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_left != '0 && !r_out_valid) |=> !r_out_valid)
        else $error("result posted before all letters were consumed");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= LEN_W'(MAX_LETTERS))
        else $error("letter count above the row length");

    a_degen_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_degen) |=> (r_left == '0))
        else $error("degenerate item started a letter sweep");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for binary_subsequence_count: directed edge items, random
// items, a no-idle stretch and a long output stall. Depends on bsc_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
    import bsc_pkg::*;

    localparam int IDLE_LIMIT = 2000;  // cycles without any transaction
    localparam int DRAIN_CYCLES = 80;  // wait after the last expected result

    typedef struct packed {
        logic [DATA_W-1:0] word_bits;
        logic [LEN_W-1:0]  word_length;
        logic [DATA_W-1:0] sub_bits;
        logic [LEN_W-1:0]  sub_length;
    } t_bsc_item;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [DATA_W-1:0]    o_m_tdata;

    logic [DATA_W-1:0] pending_counts[$];
    int error_count = 0;
    int src_max_gap = 17;
    int sink_max_gap = 17;
    int sink_wait = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    binary_subsequence_count dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // lengths above the row size saturate
    function automatic int clamp_letters(logic [LEN_W-1:0] len);
        return (len > 64) ? 64 : int'(len);
    endfunction

    // counting recurrence: each word letter feeds every matching subword cell, top down
    function automatic logic [DATA_W-1:0] count_embeddings(t_bsc_item it);
        logic [DATA_W-1:0] row [0:64];
        int wl;
        int sl;
        logic letter;
        wl = clamp_letters(it.word_length);
        sl = clamp_letters(it.sub_length);
        if (sl > wl)
            return '0;
        for (int j = 0; j <= 64; j++)
            row[j] = '0;
        row[0] = 64'd1;
        for (int i = 0; i < wl; i++) begin
            letter = it.word_bits[wl - 1 - i];
            for (int j = sl; j >= 1; j--) begin
                if (it.sub_bits[sl - j] == letter)
                    row[j] = row[j] + row[j - 1];
            end
        end
        return row[sl];
    endfunction

    function automatic t_bsc_item make_item(logic [63:0] w, int wl, logic [63:0] s, int sl);
        t_bsc_item it;
        it.word_bits   = w;
        it.word_length = LEN_W'(wl);
        it.sub_bits    = s;
        it.sub_length  = LEN_W'(sl);
        return it;
    endfunction

    function automatic t_bsc_item random_item();
        t_bsc_item it;
        int kind;
        int wl;
        int sl;
        logic [63:0] picked;
        kind = $urandom_range(0, 99);
        it.word_bits = {$urandom, $urandom};
        it.sub_bits  = {$urandom, $urandom};
        // skew letter balance now and then for large counts
        case ($urandom_range(0, 3))
            0: it.word_bits = it.word_bits & {$urandom, $urandom};
            1: it.word_bits = it.word_bits | {$urandom, $urandom};
            default: ;
        endcase
        wl = $urandom_range(1, 64);
        if (kind < 50) begin
            sl = $urandom_range(1, wl);
        end else if (kind < 75) begin
            // subword drawn from the word's own letters, garbage above its length
            sl = 0;
            picked = '0;
            for (int i = 0; i < wl; i++) begin
                if ($urandom_range(0, 1) == 0) begin
                    picked = {picked[62:0], it.word_bits[wl - 1 - i]};
                    sl++;
                end
            end
            if (sl == 0) begin
                picked = {63'd0, it.word_bits[wl - 1]};
                sl = 1;
            end
            if (sl < 64)
                it.sub_bits = (it.sub_bits << sl) | picked;
            else
                it.sub_bits = picked;
        end else if (kind < 88) begin
            wl = $urandom_range(1, 63);
            sl = $urandom_range(wl + 1, 64);
        end else begin
            wl = $urandom_range(0, 127);
            sl = $urandom_range(0, 127);
        end
        it.word_length = LEN_W'(wl);
        it.sub_length  = LEN_W'(sl);
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_item(t_bsc_item it);
        int gap;
        gap = $urandom_range(0, src_max_gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {2'b00, it.sub_length, it.sub_bits, it.word_length, it.word_bits};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        pending_counts.push_back(count_embeddings(it));
    endtask

    task automatic test_edge_cases();
        logic [63:0] r;
        r = {$urandom, $urandom};
        send_item(make_item(64'd0, 64, 64'd0, 32));
        send_item(make_item('1, 64, '1, 64));
        send_item(make_item(64'd1, 1, 64'd1, 1));
        send_item(make_item(64'd0, 1, 64'd1, 1));
        send_item(make_item(64'h5, 3, 64'hA, 4));
        send_item(make_item(r, 10, ~r, 0));
        send_item(make_item(r, 0, ~r, 5));
        send_item(make_item(r, 0, r, 0));
        send_item(make_item({$urandom, $urandom}, 127, {$urandom, $urandom}, 127));
        send_item(make_item({$urandom, $urandom}, 65, {$urandom, $urandom}, 2));
        send_item(make_item(r, 100, r, 70));
        send_item(make_item(64'hAAAA_AAAA_AAAA_AAAA, 64, 64'hFFFF_FFFF_AAAA_AAAA, 32));
        send_item(make_item(64'hFFFF_FFFF_FFFF_FFFF, 8, 64'hFFFF_FFFF_FFFF_FFF5, 3));
        send_item(make_item(64'd0, 64, '1, 64));
        send_item(make_item(64'd0, 64, 64'hFFFF_FFFF_FFFF_FFFE, 1));
        send_item(make_item(r, 64, r, 64));
        send_item(make_item('1, 64, 64'd0, 1));
        send_item(make_item(r, 63, r, 64));
        send_item(make_item(64'h2, 2, 64'h2, 2));
        send_item(make_item(64'h5555_5555_5555_5555, 64, 64'h0000_0000_0000_0001, 2));
    endtask

    task automatic test_random_items(int n);
        for (int k = 0; k < n; k++)
            send_item(random_item());
    endtask

    task automatic test_back_to_back(int n);
        src_max_gap  = 0;
        sink_max_gap = 0;
        test_random_items(n);
        src_max_gap  = 17;
        sink_max_gap = 17;
    endtask

    // receiver stops for a long stretch, sender keeps offering until the block stalls
    task automatic test_output_stall(int n);
        src_max_gap = 0;
        stall_left  = 400;
        test_random_items(n);
        src_max_gap = 17;
    endtask

    // receiver: random hold-offs between transactions, plus the long stall on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_m_tready = 1'b0;
                stall_left--;
            end else if (sink_wait > 0) begin
                i_m_tready = 1'b0;
                sink_wait--;
            end else begin
                i_m_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_counts.size() == 0)
                report_mismatch("unexpected transaction, occurrence_count", o_m_tdata, '0);
            else if (o_m_tdata !== pending_counts[0])
                report_mismatch("occurrence_count", o_m_tdata, pending_counts[0]);
            if (pending_counts.size() != 0)
                void'(pending_counts.pop_front());
            sink_wait = $urandom_range(0, sink_max_gap);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_edge_cases();
        test_random_items(700);
        test_output_stall(30);
        test_back_to_back(300);
        test_random_items(600);

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_counts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/bsc_pkg.sv
rtl/bsc_cell.sv
rtl/binary_subsequence_count.sv
tb/testbench.sv
